// ===== sv/dmma_pkg.sv =====
// Shared constants, codes and types for the dense matrix multiply-accumulate block.
package dmma_pkg;

  localparam int ROWS_I    = 8;
  localparam int COLS_J    = 8;
  localparam int INNER_K   = 8;

  localparam int IDX_W     = 3;                   // row / col / k index width
  localparam int DATA_W    = 16;                  // Q8.8 element width
  localparam int ADDR_W    = 2 * IDX_W;           // store address = {row, col}
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CFG_IDX_W = 1;

  localparam int PROD_W    = 2 * DATA_W;
  localparam int DOT_W     = PROD_W + $clog2(INNER_K);
  localparam int AB_W      = DATA_W + DOT_W;
  localparam int BC_W      = 2 * DATA_W;
  localparam int ACC_W     = AB_W + 1;
  localparam int C_SHIFT   = 8;                   // beta*C lines up with 24 frac bits
  localparam int OUT_SHIFT = 16;                  // back to Q8.8

  localparam int OUT_MAX   = 32767;
  localparam int OUT_MIN   = -32768;

  localparam logic signed [DATA_W-1:0] ALPHA_RST = 16'sd256;
  localparam logic signed [DATA_W-1:0] BETA_RST  = 16'sd0;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_LOAD_C = 2'd2,
    CMD_RUN    = 2'd3
  } dmma_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 1'b0,
    CFG_BETA  = 1'b1
  } dmma_cfg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } dmma_state_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } dmma_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                    last;
  } dmma_out_t;

  // Tag that travels with each MAC step down the pipe.
  typedef struct packed {
    logic             first;     // k == 0: start a new dot product
    logic             last_k;    // k == INNER_K-1: dot product complete
    logic             last_el;   // final element of the run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } dmma_tag_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] k;
    dmma_tag_t        tag;
  } dmma_issue_t;

endpackage

// ===== sv/dmma_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module dmma_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dmma_seq.sv =====
// Run sequencer: walks i, j, k and issues one MAC step per cycle.
module dmma_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output dmma_pkg::dmma_issue_t issue_o
);

  localparam logic [dmma_pkg::IDX_W-1:0] K_LAST = dmma_pkg::IDX_W'(dmma_pkg::INNER_K - 1);
  localparam logic [dmma_pkg::IDX_W-1:0] J_LAST = dmma_pkg::IDX_W'(dmma_pkg::COLS_J - 1);
  localparam logic [dmma_pkg::IDX_W-1:0] I_LAST = dmma_pkg::IDX_W'(dmma_pkg::ROWS_I - 1);

  dmma_pkg::dmma_state_e state_q, state_d;
  logic [dmma_pkg::IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic last_k, last_j, last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmma_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign last_k = (k_q == K_LAST);
  assign last_j = (j_q == J_LAST);
  assign last_i = (i_q == I_LAST);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      dmma_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = dmma_pkg::ST_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      dmma_pkg::ST_RUN: begin
        // counters all wrap to zero on the final step
        k_d = last_k ? '0 : k_q + 1'b1;
        if (last_k) begin
          j_d = last_j ? '0 : j_q + 1'b1;
          if (last_j) begin
            i_d = last_i ? '0 : i_q + 1'b1;
            if (last_i) begin
              state_d = dmma_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_d = dmma_pkg::ST_IDLE;
    endcase
  end

  assign busy_o              = (state_q == dmma_pkg::ST_RUN);
  assign issue_o.valid       = busy_o;
  assign issue_o.k           = k_q;
  assign issue_o.tag.first   = (k_q == '0);
  assign issue_o.tag.last_k  = last_k;
  assign issue_o.tag.last_el = last_i && last_j;
  assign issue_o.tag.row     = i_q;
  assign issue_o.tag.col     = j_q;

endmodule

// ===== sv/dmma_mac.sv =====
// MAC datapath: product, dot accumulate, alpha/beta scaling, shift and saturate.
module dmma_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dmma_pkg::dmma_issue_t                issue_i,
  input  logic signed [dmma_pkg::DATA_W-1:0]   a_rdata_i,
  input  logic signed [dmma_pkg::DATA_W-1:0]   b_rdata_i,
  input  logic signed [dmma_pkg::DATA_W-1:0]   c_rdata_i,
  input  logic signed [dmma_pkg::DATA_W-1:0]   alpha_i,
  input  logic signed [dmma_pkg::DATA_W-1:0]   beta_i,
  output logic                                 busy_o,
  output logic                                 strobe_o,
  output dmma_pkg::dmma_out_t                  result_o
);

  localparam int DATA_W = dmma_pkg::DATA_W;
  localparam int PROD_W = dmma_pkg::PROD_W;
  localparam int DOT_W  = dmma_pkg::DOT_W;
  localparam int AB_W   = dmma_pkg::AB_W;
  localparam int BC_W   = dmma_pkg::BC_W;
  localparam int ACC_W  = dmma_pkg::ACC_W;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(dmma_pkg::OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(dmma_pkg::OUT_MIN);

  // S1: memory read data valid
  logic                  v1_q;
  dmma_pkg::dmma_tag_t   tag1_q;
  // S2: product registered
  logic                  v2_q;
  dmma_pkg::dmma_tag_t   tag2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DATA_W-1:0] c2_q;
  logic signed [DOT_W-1:0]  dot_acc_q;
  logic signed [DOT_W-1:0]  dot_d;
  // S3: finished dot product
  logic                  v3_q;
  dmma_pkg::dmma_tag_t   tag3_q;
  logic signed [DOT_W-1:0]  dot3_q;
  logic signed [DATA_W-1:0] c3_q;
  // S4: scaled terms
  logic                  v4_q;
  dmma_pkg::dmma_tag_t   tag4_q;
  logic signed [AB_W-1:0]   ab_q;
  logic signed [BC_W-1:0]   bc_q;
  // S5: result
  logic                  v5_q;
  dmma_pkg::dmma_out_t   res_q;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sh;
  logic signed [DATA_W-1:0] sat;

  // control: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= issue_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q && tag2_q.last_k;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign dot_d = tag2_q.first ? DOT_W'(prod_q) : dot_acc_q + DOT_W'(prod_q);

  assign acc = ACC_W'(ab_q) + (ACC_W'(bc_q) <<< dmma_pkg::C_SHIFT);
  assign sh  = acc >>> dmma_pkg::OUT_SHIFT;

  always_comb begin
    if (sh > SAT_HI) begin
      sat = DATA_W'(dmma_pkg::OUT_MAX);
    end else if (sh < SAT_LO) begin
      sat = DATA_W'(dmma_pkg::OUT_MIN);
    end else begin
      sat = sh[DATA_W-1:0];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    tag1_q <= issue_i.tag;

    tag2_q <= tag1_q;
    prod_q <= PROD_W'(a_rdata_i) * PROD_W'(b_rdata_i);
    if (v1_q && tag1_q.first) begin
      c2_q <= c_rdata_i;       // C entry read alongside k == 0
    end

    if (v2_q) begin
      dot_acc_q <= dot_d;
    end
    if (v2_q && tag2_q.last_k) begin
      dot3_q <= dot_d;
      c3_q   <= c2_q;
      tag3_q <= tag2_q;
    end

    tag4_q <= tag3_q;
    ab_q   <= AB_W'(alpha_i) * AB_W'(dot3_q);
    bc_q   <= BC_W'(beta_i) * BC_W'(c3_q);

    res_q.out_row   <= tag4_q.row;
    res_q.out_col   <= tag4_q.col;
    res_q.out_value <= sat;
    res_q.last      <= tag4_q.last_el;
  end

  assign busy_o   = v1_q || v2_q || v3_q || v4_q || v5_q;
  assign strobe_o = v5_q;
  assign result_o = res_q;

endmodule

// ===== sv/dense_matrix_multiply_accumulate.sv =====
// Top level: C = alpha*A*B + beta*C over three element stores, Q8.8 fixed point.
//
// Usage
//   Command channel: an item (command, row, col, value) is taken at a rising
//   edge with start_i high and busy_o low. Load A/B/C writes one store entry
//   at {row, col} in that edge and leaves busy_o low, so loads run one per
//   cycle. A run command raises busy_o while the sequencer and MAC pipe are
//   active and emits every C element in row-major order.
//   Result channel: out_strobe_o marks one cycle per element; the receiver
//   cannot stall it. Each element takes INNER_K MAC steps through the single
//   read port of the A and B memories (one MAC step per cycle). An element
//   passes the read, product, dot, scaling and result registers after its
//   last MAC step; last marks the final one. Each result is also written
//   back to the C store in its strobe cycle; every C entry is sampled once
//   per run, at k == 0, before its own write, so no forwarding is needed,
//   and busy_o covers the last write.
//   Config channel: alpha (index 0) and beta (index 1), written while idle;
//   cfg_ready_o is low during a run.
//   Reset: alpha = 1.0, beta = 0, sequencer and pipe idle. Store contents
//   are not cleared; entries must be loaded before a run reads them.
module dense_matrix_multiply_accumulate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command channel
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  dmma_pkg::dmma_in_t                    cmd_i,
  // result channel
  output logic                                  out_strobe_o,
  output dmma_pkg::dmma_out_t                   result_o,
  // config channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dmma_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dmma_pkg::DATA_W-1:0]           cfg_data_i
);

  localparam int DATA_W = dmma_pkg::DATA_W;
  localparam int ADDR_W = dmma_pkg::ADDR_W;

  logic signed [DATA_W-1:0] alpha_q, beta_q;

  logic cmd_take;
  logic load_a, load_b, load_c, run_go;
  logic seq_busy, mac_busy;
  dmma_pkg::dmma_issue_t issue;

  logic [ADDR_W-1:0] load_addr, a_raddr, b_raddr, c_raddr, c_waddr;
  logic [DATA_W-1:0] c_wdata;
  logic              c_we;
  logic signed [DATA_W-1:0] a_rdata, b_rdata, c_rdata;

  assign busy_o   = seq_busy || mac_busy;
  assign cmd_take = start_i && !busy_o;

  // command decode
  always_comb begin
    load_a = 1'b0;
    load_b = 1'b0;
    load_c = 1'b0;
    run_go = 1'b0;
    if (cmd_take) begin
      unique case (dmma_pkg::dmma_cmd_e'(cmd_i.command))
        dmma_pkg::CMD_LOAD_A: load_a = 1'b1;
        dmma_pkg::CMD_LOAD_B: load_b = 1'b1;
        dmma_pkg::CMD_LOAD_C: load_c = 1'b1;
        dmma_pkg::CMD_RUN:    run_go = 1'b1;
        default:              run_go = 1'b0;
      endcase
    end
  end

  // config registers
  assign cfg_ready_o = !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= dmma_pkg::ALPHA_RST;
      beta_q  <= dmma_pkg::BETA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dmma_pkg::dmma_cfg_e'(cfg_index_i))
        dmma_pkg::CFG_ALPHA: alpha_q <= cfg_data_i;
        dmma_pkg::CFG_BETA:  beta_q  <= cfg_data_i;
        default:             alpha_q <= alpha_q;
      endcase
    end
  end

  // addressing: store entry at {row, col}
  assign load_addr = {cmd_i.row, cmd_i.col};
  assign a_raddr   = {issue.tag.row, issue.k};
  assign b_raddr   = {issue.k, issue.tag.col};
  assign c_raddr   = {issue.tag.row, issue.tag.col};

  // C write port: loads while idle, results write back during a run
  assign c_we    = load_c || out_strobe_o;
  assign c_waddr = out_strobe_o ? {result_o.out_row, result_o.out_col} : load_addr;
  assign c_wdata = out_strobe_o ? result_o.out_value : cmd_i.value;

  dmma_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (run_go),
    .busy_o  (seq_busy),
    .issue_o (issue)
  );

  dmma_ram #(
    .DEPTH (dmma_pkg::MEM_DEPTH),
    .WIDTH (DATA_W)
  ) u_a_mem (
    .clk_i   (clk_i),
    .we_i    (load_a),
    .waddr_i (load_addr),
    .wdata_i (cmd_i.value),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  dmma_ram #(
    .DEPTH (dmma_pkg::MEM_DEPTH),
    .WIDTH (DATA_W)
  ) u_b_mem (
    .clk_i   (clk_i),
    .we_i    (load_b),
    .waddr_i (load_addr),
    .wdata_i (cmd_i.value),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  dmma_ram #(
    .DEPTH (dmma_pkg::MEM_DEPTH),
    .WIDTH (DATA_W)
  ) u_c_mem (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  dmma_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .a_rdata_i (a_rdata),
    .b_rdata_i (b_rdata),
    .c_rdata_i (c_rdata),
    .alpha_i   (alpha_q),
    .beta_i    (beta_q),
    .busy_o    (mac_busy),
    .strobe_o  (out_strobe_o),
    .result_o  (result_o)
  );

endmodule

// ===== sv/dmma_chk.sv =====
// Port-level checker for the matrix multiply-accumulate block, with its bind.
module dmma_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input dmma_pkg::dmma_in_t  cmd_i,
  input logic                out_strobe_o,
  input dmma_pkg::dmma_out_t result_o
);

  // results only come out during a run
  a_strobe_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> busy_o)
    else $error("result strobe while not busy");

  // run ends right after the final element
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && result_o.last |=> !busy_o)
    else $error("busy after final element");

  // an accepted run command starts a run
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i.command == dmma_pkg::CMD_RUN) |=> busy_o)
    else $error("run command did not start a run");

  // loads leave busy_o low and produce no result strobe
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i.command != dmma_pkg::CMD_RUN)
      |=> !busy_o && !out_strobe_o)
    else $error("load command caused activity");

endmodule

bind dense_matrix_multiply_accumulate dmma_chk u_dmma_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .cmd_i        (cmd_i),
  .out_strobe_o (out_strobe_o),
  .result_o     (result_o)
);

// ===== tb/dense_matrix_multiply_accumulate_tb.sv =====
// Self-checking testbench for the dense matrix multiply-accumulate block.
module dense_matrix_multiply_accumulate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmma_pkg::*;

  // RUN_CYCLES is one run's busy time; the tail wait covers one run.
  localparam int RUN_CYCLES    = ROWS_I * COLS_J * INNER_K + 5;
  localparam int DRAIN_CYCLES  = RUN_CYCLES + 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int PHASE_ITEMS   = 28;

  // Keeps its own copy of the stores and alpha/beta, predicts every result
  // element of a run and checks the emitted elements in order.
  class gemm_scoreboard;
    logic signed [DATA_W-1:0] alpha;
    logic signed [DATA_W-1:0] beta;
    logic signed [DATA_W-1:0] a_mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] b_mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] c_mem [MEM_DEPTH];
    dmma_out_t                c_pending [$];
    int unsigned              errors;
    int unsigned              items_taken;
    int unsigned              runs_taken;
    int unsigned              elems_checked;
    int unsigned              reg_writes;

    function new();
      alpha = ALPHA_RST;
      beta  = BETA_RST;
      foreach (a_mem[n]) begin
        a_mem[n] = '0;
        b_mem[n] = '0;
        c_mem[n] = '0;
      end
      errors        = 0;
      items_taken   = 0;
      runs_taken    = 0;
      elems_checked = 0;
      reg_writes    = 0;
    endfunction

    function void write_reg(dmma_cfg_e idx, logic [DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_ALPHA: alpha = data;
        CFG_BETA:  beta  = data;
        default: ;
      endcase
    endfunction

    // Loads update a store; a run forms the whole new C and queues it.
    function void note_item(dmma_in_t it);
      int unsigned addr;
      longint      dot;
      longint      acc;
      longint      q;
      dmma_out_t   el;
      items_taken++;
      addr = (int'(it.row) << IDX_W) | int'(it.col);
      case (it.command)
        CMD_LOAD_A: a_mem[addr] = it.value;
        CMD_LOAD_B: b_mem[addr] = it.value;
        CMD_LOAD_C: c_mem[addr] = it.value;
        default: begin
          runs_taken++;
          for (int i = 0; i < ROWS_I; i++) begin
            for (int j = 0; j < COLS_J; j++) begin
              dot = 0;
              for (int k = 0; k < INNER_K; k++)
                dot += longint'(a_mem[(i << IDX_W) | k]) * longint'(b_mem[(k << IDX_W) | j]);
              acc = longint'(alpha) * dot
                  + ((longint'(beta) * longint'(c_mem[(i << IDX_W) | j])) <<< C_SHIFT);
              q = acc >>> OUT_SHIFT;            // floor division
              if (q > OUT_MAX) q = OUT_MAX;
              if (q < OUT_MIN) q = OUT_MIN;
              c_mem[(i << IDX_W) | j] = DATA_W'(q);
              el.out_row   = IDX_W'(i);
              el.out_col   = IDX_W'(j);
              el.out_value = DATA_W'(q);
              el.last      = (i == ROWS_I - 1) && (j == COLS_J - 1);
              c_pending.push_back(el);
            end
          end
        end
      endcase
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(dmma_out_t got);
      dmma_out_t want;
      if (c_pending.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result element row %0d col %0d value %0d",
                 $time, got.out_row, got.out_col, got.out_value);
        return;
      end
      want = c_pending.pop_front();
      elems_checked++;
      if (got.out_row !== want.out_row)     report("out_row", want.out_row, got.out_row);
      if (got.out_col !== want.out_col)     report("out_col", want.out_col, got.out_col);
      if (got.out_value !== want.out_value) report("out_value", want.out_value, got.out_value);
      if (got.last !== want.last)           report("last", want.last, got.last);
    endfunction

    function int unsigned outstanding();
      return c_pending.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  dmma_in_t             cmd_i       = '0;
  logic                 out_strobe_o;
  dmma_out_t            result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ALPHA;
  logic [DATA_W-1:0]    cfg_data_i  = '0;

  gemm_scoreboard sb;
  int unsigned    cycle_count = 0;

  dense_matrix_multiply_accumulate dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .out_strobe_o (out_strobe_o),
    .result_o     (result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung run never drains its result queue.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result elements still due",
               cycle_count, sb.outstanding());
      $display("** dense_matrix_multiply_accumulate: FAILED **");
      $finish;
    end
  end

  // Everything is sampled at the edge, before the block's own updates land,
  // so the values seen are the ones the block acted on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(dmma_cfg_e'(cfg_index_i), cfg_data_i);
      if (start_i && !busy_o)         sb.note_item(cmd_i);
      if (out_strobe_o)               sb.check_result(result_o);
    end
  end

  // Element values: small ones so sums stay in range, full-range random ones,
  // plus both extremes and zero so saturation and sign handling get hit often.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    int          s;
    r = $urandom_range(99);
    s = int'($urandom_range(1023)) - 512;
    if (r < 8)  return DATA_W'(OUT_MAX);
    if (r < 16) return DATA_W'(OUT_MIN);
    if (r < 20) return '0;
    if (r < 60) return DATA_W'(s);
    return DATA_W'($urandom);
  endfunction

  function automatic dmma_in_t load_item(dmma_cmd_e cmd, int unsigned r, int unsigned c,
                                         logic signed [DATA_W-1:0] v);
    dmma_in_t it;
    it.command = cmd;
    it.row     = IDX_W'(r);
    it.col     = IDX_W'(c);
    it.value   = v;
    return it;
  endfunction

  function automatic dmma_in_t run_item();
    dmma_in_t it;
    it         = dmma_in_t'($urandom);   // row/col/value are don't-care on a run
    it.command = CMD_RUN;
    return it;
  endfunction

  // Random item: about one run in seventeen, the rest loads spread over A/B/C.
  function automatic dmma_in_t random_item();
    int unsigned r;
    dmma_cmd_e   cmd;
    r = $urandom_range(99);
    if (r < 6)       return run_item();
    else if (r < 37) cmd = CMD_LOAD_A;
    else if (r < 68) cmd = CMD_LOAD_B;
    else             cmd = CMD_LOAD_C;
    return load_item(cmd, $urandom_range(ROWS_I - 1), $urandom_range(COLS_J - 1), pick_value());
  endfunction

  // Presents one item after a random number of idle cycles, then holds it
  // until the block takes it. start_i is left high; the caller lowers it.
  task automatic send_item(dmma_in_t it, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      cmd_i   <= dmma_in_t'($urandom);     // noise while idle must be ignored
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= it;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Wait for the last result element of any run, plus a short margin.
  task automatic settle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes alpha then beta back to back; valid stays high across both.
  task automatic set_scales(logic [DATA_W-1:0] alpha_val, logic [DATA_W-1:0] beta_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ALPHA;
    cfg_data_i  <= alpha_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_BETA;
    cfg_data_i  <= beta_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase: two runs back to back first so the accumulate path
  // (c_store feeding the next run) is exercised under every setting.
  task automatic random_phase(int unsigned idle_pct);
    send_item(run_item(), idle_pct);
    send_item(run_item(), idle_pct);
    for (int n = 2; n < PHASE_ITEMS; n++) send_item(random_item(), idle_pct);
    start_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every A, B and C entry is written before the first run, so no run
    // ever reads a store entry that holds nothing defined.
    for (int n = 0; n < MEM_DEPTH; n++)
      send_item(load_item(CMD_LOAD_A, n >> IDX_W, n % COLS_J, pick_value()), 13);
    for (int n = 0; n < MEM_DEPTH; n++)
      send_item(load_item(CMD_LOAD_B, n >> IDX_W, n % COLS_J, pick_value()), 13);
    for (int n = 0; n < MEM_DEPTH; n++)
      send_item(load_item(CMD_LOAD_C, n >> IDX_W, n % COLS_J, pick_value()), 13);

    // Directed part at the reset scales (alpha 1.0, beta 0).
    send_item(run_item(), 13);
    // Extreme values at the corner indices; max*max alone overflows Q8.8.
    send_item(load_item(CMD_LOAD_A, 0, 0, DATA_W'(OUT_MAX)), 13);
    send_item(load_item(CMD_LOAD_B, 0, 0, DATA_W'(OUT_MAX)), 13);
    send_item(load_item(CMD_LOAD_A, ROWS_I - 1, INNER_K - 1, DATA_W'(OUT_MIN)), 13);
    send_item(load_item(CMD_LOAD_B, INNER_K - 1, COLS_J - 1, DATA_W'(OUT_MAX)), 13);
    send_item(load_item(CMD_LOAD_A, 0, INNER_K - 1, DATA_W'(OUT_MIN)), 13);
    send_item(load_item(CMD_LOAD_B, INNER_K - 1, 0, DATA_W'(OUT_MIN)), 13);
    send_item(load_item(CMD_LOAD_C, 0, 0, DATA_W'(OUT_MIN)), 13);
    send_item(load_item(CMD_LOAD_C, ROWS_I - 1, COLS_J - 1, DATA_W'(OUT_MAX)), 13);
    // Repeated runs with no loads in between.
    send_item(run_item(), 13);
    send_item(run_item(), 13);
    start_i <= 1'b0;

    // Random phases, each under its own alpha/beta, sender idling 13%,
    // then 82%, then never.
    settle();
    set_scales(DATA_W'(OUT_MAX), DATA_W'(OUT_MIN));
    random_phase(13);
    settle();
    set_scales(DATA_W'(OUT_MIN), DATA_W'(OUT_MAX));
    random_phase(13);
    settle();
    set_scales('0, 16'sd256);
    random_phase(82);
    settle();
    set_scales(DATA_W'($urandom), DATA_W'($urandom));
    random_phase(82);
    settle();
    set_scales(16'sd256, 16'sd128);
    random_phase(0);
    settle();
    set_scales(DATA_W'($urandom), DATA_W'($urandom));
    random_phase(0);

    // Drain: every expected element, then one run's worth of quiet time so
    // any stray element would still be caught.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.outstanding() != 0)
      $display("%0d result elements never arrived", sb.outstanding());
    $display("Covered %0d items including %0d runs, %0d result elements checked, %0d reg writes",
             sb.items_taken, sb.runs_taken, sb.elems_checked, sb.reg_writes);
    $display("Scales spanned both signed extremes, zero and random; sender idle 13/82/0 pct");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** dense_matrix_multiply_accumulate: PASSED **");
    end else begin
      $display("** dense_matrix_multiply_accumulate: FAILED **");
    end
    $finish;
  end

endmodule
